// ===== rtl/core/stroke_spline_point_generator_assert.svh =====
// Assertion macros for the stroke spline point generator checker.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef STROKE_SPLINE_POINT_GENERATOR_ASSERT_SVH
`define STROKE_SPLINE_POINT_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SPG_CHECK_NOW(label, cond, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (rhs)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define SPG_CHECK_NEXT(label, cond, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (rhs)) \
        else $error(msg);

`endif

// ===== rtl/core/spg_pkg.sv =====
// Shared types and constants of the stroke spline point generator.
// Used by the interfaces, the controller, the datapath and the axis lanes.
package spg_pkg;

    // Field widths
    localparam int SPG_PID_W  = 2;
    localparam int SPG_POS_W  = 16;
    localparam int SPG_PT_W   = 24;
    localparam int SPG_STEP_W = 13;
    localparam int SPG_CNT_W  = 3;
    localparam int SPG_U_W    = 16;
    localparam int SPG_ENT_W  = 2 * SPG_POS_W;

    // Defaults
    localparam int SPG_PLAYERS = 4;
    localparam int SPG_SLOTS   = 4;

    localparam logic [SPG_STEP_W-1:0] SPG_STEP_RESET = 13'd4290;
    localparam logic [SPG_STEP_W-1:0] SPG_STEP_MIN   = 13'd1024;
    localparam logic [1:0]            SPG_LAST_SLOT  = 2'd3;
    localparam logic [SPG_CNT_W-1:0]  SPG_CNT_FULL   = 3'd4;

    // Saturation bounds in 1/256 pixel
    localparam logic signed [31:0] SPG_SAT_HI = 32'sd8388607;
    localparam logic signed [31:0] SPG_SAT_LO = -32'sd8388608;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_READ,
        OP_UPDATE,
        OP_WRITE,
        OP_COEF,
        OP_MUL_C,
        OP_ADD1,
        OP_MUL,
        OP_ADD2,
        OP_ADD3,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] idx;
    } dp_cmd_t;

    typedef struct packed {
        logic pid_ok;
        logic first_only;
        logic last;
        logic out_busy;
    } dp_status_t;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_READ_END,
        S_UPDATE,
        S_WRITE,
        S_COEF,
        S_MUL1,
        S_ADD1,
        S_MUL2,
        S_ADD2,
        S_MUL3,
        S_ADD3,
        S_EMIT
    } ctrl_state_t;

endpackage

// ===== rtl/core/spg_if.sv =====
// Valid/ready channel interfaces: pointer samples in, deposit points out.
// Depends on spg_pkg for field widths.
interface spg_in_if import spg_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic [SPG_PID_W-1:0]        player_id;
    logic signed [SPG_POS_W-1:0] pos_x;
    logic signed [SPG_POS_W-1:0] pos_y;

    modport source (output valid, output player_id, output pos_x, output pos_y,
                    input ready);
    modport sink   (input valid, input player_id, input pos_x, input pos_y,
                    output ready);
endinterface

interface spg_out_if import spg_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [SPG_PID_W-1:0]       out_player;
    logic signed [SPG_PT_W-1:0] point_x;
    logic signed [SPG_PT_W-1:0] point_y;
    logic                       last_point;

    modport source (output valid, output out_player, output point_x, output point_y,
                    output last_point, input ready);
    modport sink   (input valid, input out_player, input point_x, input point_y,
                    input last_point, output ready);
endinterface

// ===== rtl/core/spg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/spg_axis.sv =====
// One axis lane: Catmull-Rom coefficients and Horner evaluation with one multiplier.
// Depends on spg_pkg for operation codes and widths.
module spg_axis import spg_pkg::*; (
    input  logic                        clk,
    input  dp_op_t                      op,
    input  logic signed [SPG_POS_W-1:0] p0,
    input  logic signed [SPG_POS_W-1:0] p1,
    input  logic signed [SPG_POS_W-1:0] p2,
    input  logic signed [SPG_POS_W-1:0] p3,
    input  logic [SPG_U_W-1:0]          u,
    output logic signed [SPG_PT_W-1:0]  point
);

    logic signed [18:0] c3_reg, c3_next;
    logic signed [19:0] c2_reg, c2_next;
    logic signed [16:0] c1_reg, c1_next;
    logic signed [15:0] p1_reg, p1_next;
    logic signed [38:0] acc_reg, acc_next;
    logic signed [55:0] prod_reg, prod_next;
    logic signed [31:0] res_reg, res_next;

    logic signed [18:0] e0, e1, e2, e3;
    logic signed [19:0] f0, f1, f2, f3;
    logic signed [16:0] u_s;
    logic signed [55:0] sum2;
    logic signed [56:0] sum3;

    // Coefficients from the four handles
    always_comb
    begin
        e0 = 19'(p0);
        e1 = 19'(p1);
        e2 = 19'(p2);
        e3 = 19'(p3);
        f0 = 20'(p0);
        f1 = 20'(p1);
        f2 = 20'(p2);
        f3 = 20'(p3);
        c3_next = e3 - e0 + (e1 <<< 1) + e1 - (e2 <<< 1) - e2;
        c2_next = (f0 <<< 1) - (f1 <<< 2) - f1 + (f2 <<< 2) - f3;
        c1_next = 17'(p2) - 17'(p0);
        p1_next = p1;
    end

    // Horner steps; rounding constants ride in the low bits of the addends
    always_comb
    begin
        u_s       = signed'({1'b0, u});
        sum2      = prod_reg + 56'(signed'({c1_reg, 32'h0000_8000}));
        sum3      = 57'(prod_reg) + 57'(signed'({p1_reg, 33'h0_0100_0000}));
        acc_next  = acc_reg;
        prod_next = prod_reg;
        res_next  = res_reg;
        case (op)
            OP_MUL_C: prod_next = c3_reg * u_s;
            OP_ADD1:  acc_next  = 39'(prod_reg) + 39'(signed'({c2_reg, 16'h0000}));
            OP_MUL:   prod_next = acc_reg * u_s;
            OP_ADD2:  acc_next  = 39'(sum2 >>> 16);
            OP_ADD3:  res_next  = 32'(sum3 >>> 25);
            default:  ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (op == OP_COEF)
        begin
            c3_reg <= c3_next;
            c2_reg <= c2_next;
            c1_reg <= c1_next;
            p1_reg <= p1_next;
        end
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
    end

    // Saturate to the output range
    always_comb
    begin
        if (res_reg > SPG_SAT_HI)
        begin
            point = SPG_PT_W'(SPG_SAT_HI);
        end
        else if (res_reg < SPG_SAT_LO)
        begin
            point = SPG_PT_W'(SPG_SAT_LO);
        end
        else
        begin
            point = SPG_PT_W'(res_reg);
        end
    end

endmodule

// ===== rtl/core/spg_ctrl.sv =====
// Controller state machine: sequences history read, update, write-back and
// per-point evaluation. Depends on spg_pkg for states, command and status types.
module spg_ctrl import spg_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       sample_valid,
    output logic       sample_ready,
    input  dp_status_t st,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;
    logic [1:0]  idx_reg, idx_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        cmd.op       = OP_NONE;
        cmd.idx      = idx_reg;
        sample_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    cmd.op = OP_LOAD;
                    if (st.pid_ok)
                    begin
                        state_next = S_READ;
                        idx_next   = '0;
                    end
                end
            end
            S_READ:
            begin
                cmd.op = OP_READ;
                if (idx_reg == SPG_LAST_SLOT)
                begin
                    state_next = S_READ_END;
                    idx_next   = '0;
                end
                else
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end
            S_READ_END: state_next = S_UPDATE;
            S_UPDATE:
            begin
                cmd.op     = OP_UPDATE;
                state_next = S_WRITE;
                idx_next   = '0;
            end
            S_WRITE:
            begin
                cmd.op = OP_WRITE;
                if (idx_reg == SPG_LAST_SLOT)
                begin
                    state_next = st.first_only ? S_IDLE : S_COEF;
                    idx_next   = '0;
                end
                else
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end
            S_COEF:
            begin
                cmd.op     = OP_COEF;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.op     = OP_MUL_C;
                state_next = S_ADD1;
            end
            S_ADD1:
            begin
                cmd.op     = OP_ADD1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.op     = OP_MUL;
                state_next = S_ADD2;
            end
            S_ADD2:
            begin
                cmd.op     = OP_ADD2;
                state_next = S_MUL3;
            end
            S_MUL3:
            begin
                cmd.op     = OP_MUL;
                state_next = S_ADD3;
            end
            S_ADD3:
            begin
                cmd.op     = OP_ADD3;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // wait for the output register to free up
                if (!st.out_busy)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = st.last ? S_IDLE : S_MUL1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/spg_datapath.sv =====
// Datapath: history RAM and counts, handle window, parameter stepping, two axis
// lanes and the output register. Depends on spg_pkg, spg_ram and spg_axis.
module spg_datapath import spg_pkg::*; #(
    parameter int PLAYERS = SPG_PLAYERS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dp_cmd_t                     cmd,
    output dp_status_t                  st,
    input  logic [SPG_PID_W-1:0]        player_id,
    input  logic signed [SPG_POS_W-1:0] pos_x,
    input  logic signed [SPG_POS_W-1:0] pos_y,
    input  logic                        step_we,
    input  logic [SPG_STEP_W-1:0]       step_wdata,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [SPG_PID_W-1:0]        out_player,
    output logic signed [SPG_PT_W-1:0]  point_x,
    output logic signed [SPG_PT_W-1:0]  point_y,
    output logic                        last_point
);

    localparam int DEPTH = PLAYERS * SPG_SLOTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int PID_W = (PLAYERS > 1) ? $clog2(PLAYERS) : 1;

    // Control state
    logic [SPG_CNT_W-1:0]  cnt_arr_reg [PLAYERS];
    logic [SPG_STEP_W-1:0] step_reg;
    logic                  rd_pend_reg;
    logic                  out_valid_reg;

    // Payload state
    logic [SPG_PID_W-1:0]  pid_reg;
    logic [SPG_ENT_W-1:0]  entry_reg;
    logic [SPG_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [1:0]            rd_idx_reg;
    logic [SPG_ENT_W-1:0]  win_reg [SPG_SLOTS];
    logic [SPG_U_W-1:0]    u_reg;
    logic [SPG_PID_W-1:0]  out_player_reg;
    logic signed [SPG_PT_W-1:0] point_x_reg, point_y_reg;
    logic                  last_reg;

    logic [PID_W-1:0]      pidx, in_pidx;
    logic [AW-1:0]         addr;
    logic [SPG_ENT_W-1:0]  rdata;
    logic [SPG_ENT_W-1:0]  hd [SPG_SLOTS];
    logic [SPG_STEP_W-1:0] step_eff;
    logic [SPG_U_W:0]      u_sum;
    logic                  pid_ok;
    logic signed [SPG_PT_W-1:0] lane_x, lane_y;

    assign pidx    = PID_W'(pid_reg);
    assign in_pidx = PID_W'(player_id);
    assign addr    = AW'({pidx, cmd.idx});
    assign pid_ok  = 32'(player_id) < PLAYERS;

    // Parameter stepping, smallest step raised to 1/64
    assign step_eff = (step_reg < SPG_STEP_MIN) ? SPG_STEP_MIN : step_reg;
    assign u_sum    = {1'b0, u_reg} + (SPG_U_W + 1)'(step_eff);

    assign cnt_next = (cnt_reg >= SPG_CNT_FULL) ? SPG_CNT_FULL : cnt_reg + 3'd1;

    // Status to the controller
    always_comb
    begin
        st.pid_ok     = pid_ok;
        st.first_only = (cnt_reg == 3'd1);
        st.last       = u_sum[SPG_U_W];
        st.out_busy   = out_valid_reg && !out_ready;
    end

    spg_ram #(
        .WIDTH (SPG_ENT_W),
        .DEPTH (DEPTH)
    ) u_spg_ram (
        .clk   (clk),
        .we    (cmd.op == OP_WRITE),
        .waddr (addr),
        .wdata (win_reg[cmd.idx]),
        .raddr (addr),
        .rdata (rdata)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PLAYERS; i++)
            begin
                cnt_arr_reg[i] <= '0;
            end
            step_reg      <= SPG_STEP_RESET;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step_we)
            begin
                step_reg <= step_wdata;
            end
            if (cmd.op == OP_UPDATE)
            begin
                cnt_arr_reg[pidx] <= cnt_next;
            end
            rd_pend_reg <= (cmd.op == OP_READ);
            if (cmd.op == OP_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Sample latch, history window and parameter
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD && pid_ok)
        begin
            pid_reg   <= player_id;
            entry_reg <= {pos_y, pos_x};
            cnt_reg   <= cnt_arr_reg[in_pidx];
        end
        if (cmd.op == OP_READ)
        begin
            rd_idx_reg <= cmd.idx;
        end
        if (rd_pend_reg)
        begin
            win_reg[rd_idx_reg] <= rdata;
        end
        if (cmd.op == OP_UPDATE)
        begin
            cnt_reg <= cnt_next;
            case (cnt_reg)
                3'd0: win_reg[0] <= entry_reg;
                3'd1: win_reg[1] <= entry_reg;
                3'd2: win_reg[2] <= entry_reg;
                3'd3: win_reg[3] <= entry_reg;
                default:
                begin
                    // full history: drop the oldest
                    win_reg[0] <= win_reg[1];
                    win_reg[1] <= win_reg[2];
                    win_reg[2] <= win_reg[3];
                    win_reg[3] <= entry_reg;
                end
            endcase
        end
        if (cmd.op == OP_COEF)
        begin
            u_reg <= '0;
        end
        if (cmd.op == OP_EMIT)
        begin
            u_reg          <= u_sum[SPG_U_W-1:0];
            out_player_reg <= pid_reg;
            point_x_reg    <= lane_x;
            point_y_reg    <= lane_y;
            last_reg       <= u_sum[SPG_U_W];
        end
    end

    // Handle selection for short histories
    always_comb
    begin
        case (cnt_reg)
            3'd2:
            begin
                hd[0] = win_reg[0];
                hd[1] = win_reg[0];
                hd[2] = win_reg[1];
                hd[3] = win_reg[1];
            end
            3'd3:
            begin
                hd[0] = win_reg[0];
                hd[1] = win_reg[0];
                hd[2] = win_reg[1];
                hd[3] = win_reg[2];
            end
            default:
            begin
                hd[0] = win_reg[0];
                hd[1] = win_reg[1];
                hd[2] = win_reg[2];
                hd[3] = win_reg[3];
            end
        endcase
    end

    spg_axis u_spg_axis_x (
        .clk   (clk),
        .op    (cmd.op),
        .p0    (signed'(hd[0][SPG_POS_W-1:0])),
        .p1    (signed'(hd[1][SPG_POS_W-1:0])),
        .p2    (signed'(hd[2][SPG_POS_W-1:0])),
        .p3    (signed'(hd[3][SPG_POS_W-1:0])),
        .u     (u_reg),
        .point (lane_x)
    );

    spg_axis u_spg_axis_y (
        .clk   (clk),
        .op    (cmd.op),
        .p0    (signed'(hd[0][SPG_ENT_W-1:SPG_POS_W])),
        .p1    (signed'(hd[1][SPG_ENT_W-1:SPG_POS_W])),
        .p2    (signed'(hd[2][SPG_ENT_W-1:SPG_POS_W])),
        .p3    (signed'(hd[3][SPG_ENT_W-1:SPG_POS_W])),
        .u     (u_reg),
        .point (lane_y)
    );

    assign out_valid  = out_valid_reg;
    assign out_player = out_player_reg;
    assign point_x    = point_x_reg;
    assign point_y    = point_y_reg;
    assign last_point = last_reg;

endmodule

// ===== rtl/core/stroke_spline_point_generator.sv =====
// Per sample: history read, update and write-back through one RAM, then for each point
// three multiply/add pairs in the shared lane multiplier, plus emit.
// N = ceil(65536/step) points per sample, step raised to at least 1024, so at most 64; a
// player's first sample yields no points, and a sample for an absent player is dropped.
// A held deposit beat stalls the emit step; no new sample is taken before the last emit.
// Reset: history counts cleared, step back to 4290; history RAM is not cleared.
module stroke_spline_point_generator import spg_pkg::*; #(
    parameter int PLAYERS = SPG_PLAYERS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    spg_in_if.sink                sample,
    spg_out_if.source             deposit,
    input  logic                  step_we,
    input  logic [SPG_STEP_W-1:0] step_wdata
);

    dp_cmd_t    cmd;
    dp_status_t st;

    // Sequencer
    spg_ctrl u_spg_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample.valid),
        .sample_ready (sample.ready),
        .st           (st),
        .cmd          (cmd)
    );

    // Storage and arithmetic
    spg_datapath #(
        .PLAYERS (PLAYERS)
    ) u_spg_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .player_id  (sample.player_id),
        .pos_x      (sample.pos_x),
        .pos_y      (sample.pos_y),
        .step_we    (step_we),
        .step_wdata (step_wdata),
        .out_ready  (deposit.ready),
        .out_valid  (deposit.valid),
        .out_player (deposit.out_player),
        .point_x    (deposit.point_x),
        .point_y    (deposit.point_y),
        .last_point (deposit.last_point)
    );

endmodule

// ===== rtl/core/spg_checker.sv =====
// Port-level checker for the stroke spline point generator, bound to the top level.
// Depends on spg_pkg, the assertion macro header and the channel interfaces.
`include "stroke_spline_point_generator_assert.svh"

module spg_checker import spg_pkg::*; #(
    parameter int PLAYERS = SPG_PLAYERS
) (
    input logic       clk,
    input logic       rst_n,
    spg_in_if.sink    sample,
    spg_out_if.source deposit
);

    // A stalled deposit beat holds
    `SPG_CHECK_NEXT(a_deposit_hold, deposit.valid && !deposit.ready, deposit.valid && $stable(deposit.point_x) && $stable(deposit.point_y) && $stable(deposit.last_point) && $stable(deposit.out_player), "deposit beat changed while stalled")

    // A sample for a present player occupies the block
    `SPG_CHECK_NEXT(a_busy_after_sample, sample.valid && sample.ready && (32'(sample.player_id) < PLAYERS), !sample.ready, "sample accepted while previous one in flight")

    // More points pending means no new sample
    `SPG_CHECK_NOW(a_busy_mid_stroke, deposit.valid && !deposit.last_point, !sample.ready, "sample ready before final point")

endmodule

bind stroke_spline_point_generator spg_checker #(
    .PLAYERS (PLAYERS)
) u_spg_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .sample  (sample),
    .deposit (deposit)
);

// ===== verif/tb_stroke_spline_point_generator.sv =====
// Testbench for stroke_spline_point_generator: feeds pointer samples per player and
// checks every deposit point beat against a Catmull-Rom predictor, in order.
// Depends on spg_pkg and the spg_in_if / spg_out_if channel interfaces.
module tb_stroke_spline_point_generator;
    import spg_pkg::*;

    localparam int     CLK_HALF     = 5;
    localparam int     RESET_CYCLES = 9;
    localparam int     DRAIN_CYCLES = 40;
    localparam longint CYCLE_LIMIT  = 1000000;
    localparam int     MAX_REPORTS  = 10;
    localparam int     U_ONE        = 65536;
    localparam int     PTS_MAX      = 64;
    localparam int     HOLD_CYCLES  = 600;

    typedef struct packed {
        logic [SPG_PID_W-1:0]        player;
        logic signed [SPG_POS_W-1:0] x;
        logic signed [SPG_POS_W-1:0] y;
    } sample_t;

    typedef struct packed {
        logic [SPG_PID_W-1:0]       player;
        logic signed [SPG_PT_W-1:0] x;
        logic signed [SPG_PT_W-1:0] y;
        logic                       last;
    } deposit_t;

    logic                  clk;
    logic                  rst_n;
    logic                  step_we;
    logic [SPG_STEP_W-1:0] step_wdata;

    spg_in_if  sample ();
    spg_out_if deposit ();

    stroke_spline_point_generator DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .deposit    (deposit),
        .step_we    (step_we),
        .step_wdata (step_wdata)
    );

    // Predictor state: step register and per-player history
    logic [SPG_STEP_W-1:0]       model_step;
    logic signed [SPG_POS_W-1:0] hist_x [SPG_PLAYERS][SPG_SLOTS];
    logic signed [SPG_POS_W-1:0] hist_y [SPG_PLAYERS][SPG_SLOTS];
    int                          hist_cnt [SPG_PLAYERS];

    sample_t  samples_pending[$];
    deposit_t deposits_due[$];

    // Stimulus generator state
    int gen_x [SPG_PLAYERS];
    int gen_y [SPG_PLAYERS];

    int     src_idle_pct;
    int     sink_stall_pct;
    logic   hold_go;
    logic   hold_seen;
    int     hold_left;
    int     mismatch_count = 0;
    longint cycles = 0;

    sample_t  next_sample;
    sample_t  seen_sample;
    deposit_t got_pt;
    deposit_t want_pt;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // One axis of the Hermite point, tension and bias zero, 1/256 pixel, saturated
    function automatic logic signed [SPG_PT_W-1:0] spline_axis(
        input longint p0, input longint p1, input longint p2, input longint p3,
        input longint u);
        longint c3, c2, c1, h;
        c3 = -p0 + 3 * p1 - 3 * p2 + p3;
        c2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        c1 = p2 - p0;
        h = c3 * u + (c2 <<< 16);
        h = h * u + (c1 <<< 32);
        h = (h + 64'sd32768) >>> 16;
        h = h * u + ((2 * p1) <<< 32);
        h = (h + 64'sd16777216) >>> 25;
        if (h > SPG_SAT_HI)
            h = SPG_SAT_HI;
        if (h < SPG_SAT_LO)
            h = SPG_SAT_LO;
        return h[SPG_PT_W-1:0];
    endfunction

    // Update the player's history and queue the deposit points of one sample
    task automatic predict_deposits(input sample_t s);
        int       pid, cnt, step, u, n;
        int       idx [4];
        longint   hx [4];
        longint   hy [4];
        deposit_t d;
        pid = s.player;
        cnt = hist_cnt[pid];
        if (cnt >= SPG_SLOTS)
        begin
            for (int i = 0; i < SPG_SLOTS - 1; i++)
            begin
                hist_x[pid][i] = hist_x[pid][i+1];
                hist_y[pid][i] = hist_y[pid][i+1];
            end
            hist_x[pid][SPG_SLOTS-1] = s.x;
            hist_y[pid][SPG_SLOTS-1] = s.y;
            cnt = SPG_SLOTS;
        end
        else
        begin
            hist_x[pid][cnt] = s.x;
            hist_y[pid][cnt] = s.y;
            cnt++;
        end
        hist_cnt[pid] = cnt;

        // first sample of a stroke deposits nothing
        if (cnt > 1)
        begin
            // short histories repeat the oldest entries as handles
            case (cnt)
                2:       idx = '{0, 0, 1, 1};
                3:       idx = '{0, 0, 1, 2};
                default: idx = '{0, 1, 2, 3};
            endcase
            for (int i = 0; i < 4; i++)
            begin
                hx[i] = hist_x[pid][idx[i]];
                hy[i] = hist_y[pid][idx[i]];
            end
            step = (model_step < SPG_STEP_MIN) ? int'(SPG_STEP_MIN) : int'(model_step);
            n = 0;
            for (u = 0; u < U_ONE && n < PTS_MAX; u += step)
            begin
                d.player = s.player;
                d.x      = spline_axis(hx[0], hx[1], hx[2], hx[3], u);
                d.y      = spline_axis(hy[0], hy[1], hy[2], hy[3], u);
                d.last   = (u + step >= U_ONE);
                deposits_due = {deposits_due, d};
                n++;
            end
        end
    endtask

    // Sample driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sample.valid     <= 1'b0;
            sample.player_id <= '0;
            sample.pos_x     <= '0;
            sample.pos_y     <= '0;
        end
        else if (!sample.valid || sample.ready)
        begin
            if (samples_pending.size() > 0 && $urandom_range(99) >= src_idle_pct)
            begin
                next_sample = samples_pending.pop_front();
                sample.valid     <= 1'b1;
                sample.player_id <= next_sample.player;
                sample.pos_x     <= next_sample.x;
                sample.pos_y     <= next_sample.y;
            end
            else
                sample.valid <= 1'b0;
        end
    end

    // Predict on every accepted sample beat
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < SPG_PLAYERS; p++)
                hist_cnt[p] = 0;
        end
        else if (sample.valid && sample.ready)
        begin
            seen_sample.player = sample.player_id;
            seen_sample.x      = sample.pos_x;
            seen_sample.y      = sample.pos_y;
            predict_deposits(seen_sample);
        end
    end

    // Deposit receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            deposit.ready <= 1'b0;
            hold_seen     <= hold_go;
            hold_left     <= 0;
        end
        else if (hold_go != hold_seen)
        begin
            hold_seen     <= hold_go;
            hold_left     <= HOLD_CYCLES;
            deposit.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            deposit.ready <= 1'b0;
        end
        else
            deposit.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Check each deposit beat against the oldest expected point
    always @(posedge clk)
    begin
        if (rst_n && deposit.valid && deposit.ready)
        begin
            got_pt.player = deposit.out_player;
            got_pt.x      = deposit.point_x;
            got_pt.y      = deposit.point_y;
            got_pt.last   = deposit.last_point;
            if (deposits_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected deposit: player %0d x %0d y %0d last %0b",
                             got_pt.player, got_pt.x, got_pt.y, got_pt.last);
            end
            else
            begin
                want_pt = deposits_due.pop_front();
                if (got_pt.player !== want_pt.player || got_pt.x !== want_pt.x ||
                    got_pt.y !== want_pt.y || got_pt.last !== want_pt.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("deposit mismatch: expected p%0d x %0d y %0d last %0b, got p%0d x %0d y %0d last %0b",
                                 want_pt.player, want_pt.x, want_pt.y, want_pt.last,
                                 got_pt.player, got_pt.x, got_pt.y, got_pt.last);
                end
            end
        end
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_stroke_spline_point_generator failed");
            $finish;
        end
    end

    // Wait until all samples are taken and all points have arrived, then drain
    task automatic wait_idle();
        while (samples_pending.size() > 0 || sample.valid || deposits_due.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_step(input int value);
        wait_idle();
        @(posedge clk);
        step_we    <= 1'b1;
        step_wdata <= value[SPG_STEP_W-1:0];
        @(posedge clk);
        step_we    <= 1'b0;
        model_step = value[SPG_STEP_W-1:0];
    endtask

    task automatic set_idling(input int src_pct, input int sink_pct);
        @(negedge clk);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
    endtask

    task automatic push_sample(input int pid, input int x, input int y);
        sample_t s;
        s.player = pid[SPG_PID_W-1:0];
        s.x      = x[SPG_POS_W-1:0];
        s.y      = y[SPG_POS_W-1:0];
        gen_x[pid] = s.x;
        gen_y[pid] = s.y;
        samples_pending = {samples_pending, s};
    endtask

    // Mostly smooth strokes, some jumps anywhere, some extreme positions
    task automatic push_strokes(input int count);
        int pid, kind, x, y;
        for (int i = 0; i < count; i++)
        begin
            pid  = $urandom_range(SPG_PLAYERS - 1);
            kind = $urandom_range(99);
            if (kind < 70)
            begin
                x = gen_x[pid] + int'($urandom_range(400)) - 200;
                y = gen_y[pid] + int'($urandom_range(400)) - 200;
            end
            else if (kind < 88)
            begin
                x = $urandom;
                y = $urandom;
            end
            else
            begin
                x = $urandom_range(1) ? 32767 : -32768;
                y = $urandom_range(1) ? -1 : 0;
            end
            push_sample(pid, x, y);
        end
    endtask

    // Main sequence
    initial
    begin
        rst_n            = 1'b0;
        step_we          = 1'b0;
        step_wdata       = '0;
        src_idle_pct     = 0;
        sink_stall_pct   = 0;
        hold_go          = 1'b0;
        model_step       = SPG_STEP_RESET;
        for (int p = 0; p < SPG_PLAYERS; p++)
        begin
            gen_x[p] = 0;
            gen_y[p] = 0;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed strokes at the reset step, no idling
        @(negedge clk);
        push_sample(0, 0, 0);
        push_sample(0, 100, -50);
        push_sample(0, -32768, 32767);
        push_sample(0, 32767, -32768);
        push_sample(0, 5, 5);
        push_sample(1, 32767, 32767);
        push_sample(3, -32768, -32768);
        push_sample(1, 32767, 32767);
        push_sample(3, -32768, -32768);
        push_sample(1, -1, -1);
        push_sample(3, 1, -1);
        push_sample(3, -1, 1);
        // bulging segment drives both axes into saturation
        push_sample(2, -32768, 32767);
        push_sample(2, 32767, -32768);
        push_sample(2, 32767, -32768);
        push_sample(2, -32768, 32767);
        push_sample(2, 0, 0);

        // Step below the floor: 64 points per sample
        write_step(0);
        set_idling(28, 28);
        push_strokes(12);

        // Largest step
        write_step(8191);
        set_idling(82, 0);
        push_strokes(20);

        write_step(int'(SPG_STEP_MIN) - 1);
        set_idling(0, 82);
        push_strokes(12);

        // Long receiver hold-off while samples keep coming
        write_step(6554);
        set_idling(0, 0);
        hold_go = ~hold_go;
        push_strokes(10);

        write_step(SPG_STEP_MIN);
        set_idling(0, 0);
        push_strokes(10);

        write_step($urandom_range(6554, 1024));
        set_idling(28, 28);
        push_strokes(15);

        write_step($urandom_range(8191));
        set_idling(82, 0);
        push_strokes(14);

        wait_idle();
        if (mismatch_count == 0)
            $display("tb_stroke_spline_point_generator passed");
        else
            $display("tb_stroke_spline_point_generator failed");
        $finish;
    end

endmodule
